### rtl/pcbs_pkg.sv
// ----------------------------------------------------------------------------
// pcbs_pkg
// Shared types, codes and helpers of the particle cell binning sampler.
// ----------------------------------------------------------------------------
package pcbs_pkg;

	localparam int CELLS_X_DEF    = 16;
	localparam int CELLS_Y_DEF    = 16;
	localparam int CELLS_Z_DEF    = 16;
	localparam int LIST_DEPTH_DEF = 32;

	// item modes
	localparam logic [1:0] MODE_STEP    = 2'd0;
	localparam logic [1:0] MODE_PART    = 2'd1;
	localparam logic [1:0] MODE_RD_CELL = 2'd2;
	localparam logic [1:0] MODE_RD_LIST = 2'd3;

	// register indexes
	localparam logic [1:0] REG_INV_X = 2'd0;
	localparam logic [1:0] REG_INV_Y = 2'd1;
	localparam logic [1:0] REG_INV_Z = 2'd2;

	localparam logic [15:0] INV_RESET = 16'd256;

	typedef struct packed {
		logic accept;
		logic clear;
		logic issue;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
	} stat_t;

	typedef struct packed {
		logic [31:0] tag;
		logic [15:0] occ;
	} occ_t;

	typedef struct packed {
		logic [31:0] count;
		logic [47:0] vx;
		logic [47:0] vy;
		logic [47:0] vz;
		logic [63:0] sq;
	} mom_t;

	typedef struct packed {
		logic [11:0] cell_index;
		logic [4:0]  slot;
		logic        overflow;
		logic [15:0] occupancy;
		mom_t        mom;
		logic [31:0] step_count;
		logic [15:0] listed_id;
	} res_t;

	// floor of a Q16.24 product, negative to zero, clamped to the grid edge
	function automatic logic [15:0] bin_coord(input logic signed [40:0] p,
		input logic [15:0] cells);
		logic [15:0] hi;
		hi = p[39:24];
		if (p[40])
			return '0;
		else if (hi >= cells)
			return cells - 16'd1;
		else
			return hi;
	endfunction

endpackage

### rtl/pcbs_ctrl.sv
// ----------------------------------------------------------------------------
// pcbs_ctrl
// Sequencer: clearing pass, then one item at a time through the datapath.
// ----------------------------------------------------------------------------
module pcbs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  pcbs_pkg::stat_t stat,
	output pcbs_pkg::cmd_t  cmd
);
	import pcbs_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_IDX,
		ST_RD,
		ST_UPD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   commit;

	assign commit = (state_q == ST_UPD) && (!out_valid_q || !out_stall);

	always_comb begin
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.clear  = (state_q == ST_CLEAR);
		cmd.issue  = (state_q == ST_RD);
		cmd.commit = commit;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (commit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: if (stat.clear_done) state_q <= ST_IDLE;
				ST_IDLE:  if (in_valid) state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_IDX;
				ST_IDX:   state_q <= ST_RD;
				ST_RD:    state_q <= ST_UPD;
				ST_UPD:   if (commit) state_q <= ST_IDLE;
				default:  state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

### rtl/pcbs_dp.sv
// ----------------------------------------------------------------------------
// pcbs_dp
// Datapath: binning arithmetic, cell memories, list memory, result register.
// ----------------------------------------------------------------------------
module pcbs_dp #(
	parameter int CELLS_X    = pcbs_pkg::CELLS_X_DEF,
	parameter int CELLS_Y    = pcbs_pkg::CELLS_Y_DEF,
	parameter int CELLS_Z    = pcbs_pkg::CELLS_Z_DEF,
	parameter int LIST_DEPTH = pcbs_pkg::LIST_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pcbs_pkg::cmd_t    cmd,
	output pcbs_pkg::stat_t   stat,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic [1:0]        mode,
	input  logic [15:0]       particle_id,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic signed [15:0] vel_z,
	input  logic [11:0]       query_cell,
	input  logic [4:0]        query_slot,
	output pcbs_pkg::res_t    res
);
	import pcbs_pkg::*;

	localparam int NCELLS = CELLS_X * CELLS_Y * CELLS_Z;
	localparam int MDEPTH = NCELLS * LIST_DEPTH;
	localparam int CW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
	localparam int MW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
	localparam int XW     = (CELLS_X > 1) ? $clog2(CELLS_X) : 1;
	localparam int YW     = (CELLS_Y > 1) ? $clog2(CELLS_Y) : 1;
	localparam int ZW     = (CELLS_Z > 1) ? $clog2(CELLS_Z) : 1;

	// configuration
	logic [15:0] inv_x_q, inv_y_q, inv_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_x_q <= INV_RESET;
			inv_y_q <= INV_RESET;
			inv_z_q <= INV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INV_X: inv_x_q <= cfg_data;
				REG_INV_Y: inv_y_q <= cfg_data;
				REG_INV_Z: inv_z_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// accepted item
	logic [1:0]         mode_s1;
	logic [15:0]        id_s1;
	logic signed [23:0] px_s1, py_s1, pz_s1;
	logic signed [15:0] vx_s1, vy_s1, vz_s1;
	logic [11:0]        qcell_s1;
	logic [4:0]         qslot_s1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_s1  <= mode;
			id_s1    <= particle_id;
			px_s1    <= pos_x;
			py_s1    <= pos_y;
			pz_s1    <= pos_z;
			vx_s1    <= vel_x;
			vy_s1    <= vel_y;
			vz_s1    <= vel_z;
			qcell_s1 <= query_cell;
			qslot_s1 <= query_slot;
		end
	end

	// position products and velocity squares
	logic signed [40:0] prod_x, prod_y, prod_z;
	logic [15:0]        cx, cy, cz;
	logic signed [31:0] sqx, sqy, sqz;
	logic [XW-1:0]      kx_s2;
	logic [YW-1:0]      ky_s2;
	logic [ZW-1:0]      kz_s2;
	logic [31:0]        sqx_s2, sqy_s2, sqz_s2;

	always_comb begin
		prod_x = $signed(px_s1) * $signed({1'b0, inv_x_q});
		prod_y = $signed(py_s1) * $signed({1'b0, inv_y_q});
		prod_z = $signed(pz_s1) * $signed({1'b0, inv_z_q});
		cx     = bin_coord(prod_x, 16'(CELLS_X));
		cy     = bin_coord(prod_y, 16'(CELLS_Y));
		cz     = bin_coord(prod_z, 16'(CELLS_Z));
		sqx    = vx_s1 * vx_s1;
		sqy    = vy_s1 * vy_s1;
		sqz    = vz_s1 * vz_s1;
	end

	always_ff @(posedge clk) begin
		kx_s2  <= cx[XW-1:0];
		ky_s2  <= cy[YW-1:0];
		kz_s2  <= cz[ZW-1:0];
		sqx_s2 <= sqx;
		sqy_s2 <= sqy;
		sqz_s2 <= sqz;
	end

	// cell address and list address
	logic [31:0]   flat, qwide, sbase;
	logic          qin;
	logic [CW-1:0] addr_q;
	logic [MW-1:0] base_q, maddr_q;
	logic          in_grid_q;
	logic [63:0]   sq_s3;

	always_comb begin
		flat  = (32'(kx_s2) * 32'(CELLS_Y) + 32'(ky_s2)) * 32'(CELLS_Z) + 32'(kz_s2);
		qwide = 32'(qcell_s1);
		qin   = qwide < 32'(NCELLS);
		if (mode_s1 == MODE_PART)
			sbase = flat;
		else if (qin)
			sbase = qwide;
		else
			sbase = '0;
	end

	always_ff @(posedge clk) begin
		addr_q    <= sbase[CW-1:0];
		base_q    <= MW'(sbase * 32'(LIST_DEPTH));
		maddr_q   <= MW'(sbase * 32'(LIST_DEPTH)
			+ ((32'(qslot_s1) < 32'(LIST_DEPTH)) ? 32'(qslot_s1) : 32'd0));
		in_grid_q <= qin;
		sq_s3     <= 64'(sqx_s2) + 64'(sqy_s2) + 64'(sqz_s2);
	end

	// memories
	occ_t        occ_mem [NCELLS];
	mom_t        mom_mem [NCELLS];
	logic [15:0] mem_ids [MDEPTH];
	occ_t        occ_rd_q;
	mom_t        mom_rd_q;
	logic [15:0] id_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			occ_rd_q <= occ_mem[addr_q];
			mom_rd_q <= mom_mem[addr_q];
			id_rd_q  <= mem_ids[maddr_q];
		end
	end

	// clearing pass
	logic [CW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clear)
			clr_q <= clr_q + CW'(1);
	end

	assign stat.clear_done = (clr_q == CW'(NCELLS - 1));

	// update
	logic [31:0]   step_q;
	logic [15:0]   occ_eff, occ_new;
	logic          full;
	mom_t          mom_new;
	logic          part_commit, cell_we;
	logic [CW-1:0] cell_wa;
	occ_t          occ_wd;
	mom_t          mom_wd;
	logic          slot_ok;
	res_t          res_d;

	always_comb begin
		occ_eff       = (occ_rd_q.tag == step_q) ? occ_rd_q.occ : 16'd0;
		full          = occ_eff >= 16'(LIST_DEPTH);
		occ_new       = (occ_eff == 16'hFFFF) ? occ_eff : occ_eff + 16'd1;
		mom_new.count = mom_rd_q.count + 32'd1;
		mom_new.vx    = mom_rd_q.vx + 48'(vx_s1);
		mom_new.vy    = mom_rd_q.vy + 48'(vy_s1);
		mom_new.vz    = mom_rd_q.vz + 48'(vz_s1);
		mom_new.sq    = mom_rd_q.sq + sq_s3;
		part_commit   = cmd.commit && (mode_s1 == MODE_PART);
		cell_we       = cmd.clear || part_commit;
		cell_wa       = cmd.clear ? clr_q : addr_q;
		occ_wd        = cmd.clear ? occ_t'('0) : occ_t'({step_q, occ_new});
		mom_wd        = cmd.clear ? mom_t'('0) : mom_new;
		slot_ok       = (32'(qslot_s1) < 32'(LIST_DEPTH)) && (16'(qslot_s1) < occ_eff);
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			occ_mem[cell_wa] <= occ_wd;
			mom_mem[cell_wa] <= mom_wd;
		end
		if (part_commit && !full)
			mem_ids[base_q + MW'(occ_eff)] <= id_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= '0;
		else if (cmd.commit && (mode_s1 == MODE_STEP))
			step_q <= step_q + 32'd1;
	end

	// result register
	always_comb begin
		res_d            = '0;
		res_d.step_count = step_q;
		case (mode_s1)
			MODE_STEP: begin
				res_d.step_count = step_q + 32'd1;
			end
			MODE_PART: begin
				res_d.cell_index = 12'(addr_q);
				res_d.slot       = full ? 5'd0 : occ_eff[4:0];
				res_d.overflow   = full;
				res_d.occupancy  = occ_new;
				res_d.mom        = mom_new;
			end
			default: begin
				res_d.cell_index = qcell_s1;
				if (mode_s1 == MODE_RD_LIST)
					res_d.slot = qslot_s1;
				if (in_grid_q) begin
					res_d.occupancy = occ_eff;
					res_d.mom       = mom_rd_q;
					if (mode_s1 == MODE_RD_LIST && slot_ok)
						res_d.listed_id = id_rd_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit)
			res <= res_d;
	end

endmodule

### rtl/particle_cell_binning_sampler_top.sv
// ----------------------------------------------------------------------------
// particle_cell_binning_sampler_top
// Bins particles into a 3-D grid of cells and keeps per-cell velocity moments.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ------------------------------------------
//  in       in_valid / in_stall  mode, particle_id, pos_*, vel_*, query_*
//  out      out_valid/out_stall  cell_index ... listed_id
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  An item goes through multiply, index and memory read, then one
//  read-modify-write of the cell memories, before the next acceptance.
//  After reset the cell memories are cleared one cell a cycle, all CELLS_X *
//  CELLS_Y * CELLS_Z cells (4096 by default); in_stall stays high meanwhile.
//  A waiting result does not block acceptance; the update waits for a free
//  output register, so a stalled output holds back the following item only.
//  A begin step bumps the step counter; occupancies carry the step they were
//  written in, so older ones read as zero.
//
module particle_cell_binning_sampler_top #(
	parameter int CELLS_X    = pcbs_pkg::CELLS_X_DEF,
	parameter int CELLS_Y    = pcbs_pkg::CELLS_Y_DEF,
	parameter int CELLS_Z    = pcbs_pkg::CELLS_Z_DEF,
	parameter int LIST_DEPTH = pcbs_pkg::LIST_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [15:0]        particle_id,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic signed [15:0] vel_z,
	input  logic [11:0]        query_cell,
	input  logic [4:0]         query_slot,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [11:0]        cell_index,
	output logic [4:0]         slot,
	output logic               overflow,
	output logic [15:0]        occupancy,
	output logic [31:0]        total_count,
	output logic signed [47:0] sum_vel_x,
	output logic signed [47:0] sum_vel_y,
	output logic signed [47:0] sum_vel_z,
	output logic [63:0]        sum_speed_sq,
	output logic [31:0]        step_count,
	output logic [15:0]        listed_id
);
	import pcbs_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	res_t  res;

	// registers are to be written only while idle; the block itself does not enforce this, so take every transaction
	assign cfg_ready = 1'b1;

	pcbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pcbs_dp #(
		.CELLS_X    (CELLS_X),
		.CELLS_Y    (CELLS_Y),
		.CELLS_Z    (CELLS_Z),
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mode        (mode),
		.particle_id (particle_id),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.vel_z       (vel_z),
		.query_cell  (query_cell),
		.query_slot  (query_slot),
		.res         (res)
	);

	// split the result register onto the ports
	assign cell_index   = res.cell_index;
	assign slot         = res.slot;
	assign overflow     = res.overflow;
	assign occupancy    = res.occupancy;
	assign total_count  = res.mom.count;
	assign sum_vel_x    = $signed(res.mom.vx);
	assign sum_vel_y    = $signed(res.mom.vy);
	assign sum_vel_z    = $signed(res.mom.vz);
	assign sum_speed_sq = res.mom.sq;
	assign step_count   = res.step_count;
	assign listed_id    = res.listed_id;

`ifndef ASSERT_OFF
	// one item at a time: an accepted transaction leaves the input stalled
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while an item is in flight");

	// never overwrite a result that is still waiting
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");

	// a dropped id reports slot zero
	a_overflow_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> slot == 5'd0)
		else $error("overflow with non-zero slot");
`endif

endmodule
